FILE: src/acf_pkg.sv
// ----------------------------------------------------------------------------
// acf_pkg: shared types and constants
// Opcodes, register indexes, reset values, word and result structs, face map.
// ----------------------------------------------------------------------------
package acf_pkg;

  typedef enum logic [1:0] {
    OP_OBSERVE = 2'd0,
    OP_UPDATE  = 2'd1,
    OP_HALT    = 2'd2,
    OP_RESET   = 2'd3
  } op_t;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CONF   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INST_CONF  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CONF_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DWELL      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FACE_MAP   = 3'd7;

  localparam logic        RST_ENABLE     = 1'b1;
  localparam logic [7:0]  RST_MIN_CONF   = 8'd128;
  localparam logic [7:0]  RST_INST_CONF  = 8'd230;
  localparam logic [7:0]  RST_CONF_COUNT = 8'd3;
  localparam logic [31:0] RST_DWELL      = 32'd0;
  localparam logic [31:0] RST_STALE      = 32'd2000;
  localparam logic [31:0] RST_HOLD       = 32'd500;
  localparam logic [20:0] RST_FACE_MAP   = 21'd0;

  localparam logic [2:0] CLS_UNKNOWN = 3'd0;
  localparam logic [2:0] FACE_IDLE   = 3'd0;
  localparam logic [2:0] FACE_MAX    = 3'd5;
  localparam logic [7:0] REPEAT_MAX  = 8'd255;

  localparam int CNT_NUM      = 7;
  localparam int CNT_OBSERVED = 0;
  localparam int CNT_UNKNOWN  = 1;
  localparam int CNT_WEAK     = 2;
  localparam int CNT_ACCEPTED = 3;
  localparam int CNT_DECAYS   = 4;
  localparam int CNT_HELD     = 5;
  localparam int CNT_CHANGES  = 6;

  typedef struct packed {
    logic        enable;
    logic [7:0]  conf_floor;
    logic [7:0]  conf_instant;
    logic [7:0]  confirm_count;
    logic [31:0] promote_dwell;
    logic [31:0] stale_after;
    logic [31:0] hold_time;
    logic [20:0] face_map;
  } cfg_t;

  typedef struct packed {
    op_t         opcode;
    logic [2:0]  affect;
    logic [7:0]  confidence;
    logic [31:0] now_ms;
    logic        halt_on;
    logic        mute;
  } item_t;

  typedef struct packed {
    logic [2:0]                 face;
    logic                       emit_new;
    logic [2:0]                 confirmed_affect;
    logic [CNT_NUM-1:0][31:0]   cnt;
  } res_t;

  function automatic logic [2:0] face_for(logic [20:0] fmap, logic [2:0] cls);
    logic [2:0] code;
    code = FACE_IDLE;
    if (cls != CLS_UNKNOWN) code = fmap[(int'(cls) - 1) * 3 +: 3];
    if (code > FACE_MAX) code = FACE_IDLE;
    return code;
  endfunction

endpackage

FILE: src/acf_cfg.sv
// ----------------------------------------------------------------------------
// acf_cfg: configuration register file
// Holds the eight settings, written one word at a time by index.
// ----------------------------------------------------------------------------
module acf_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [acf_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [31:0]                      wr_data,
  output acf_pkg::cfg_t                    cfg
);

  acf_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable        <= acf_pkg::RST_ENABLE;
      cfg_r.conf_floor    <= acf_pkg::RST_MIN_CONF;
      cfg_r.conf_instant  <= acf_pkg::RST_INST_CONF;
      cfg_r.confirm_count <= acf_pkg::RST_CONF_COUNT;
      cfg_r.promote_dwell <= acf_pkg::RST_DWELL;
      cfg_r.stale_after   <= acf_pkg::RST_STALE;
      cfg_r.hold_time     <= acf_pkg::RST_HOLD;
      cfg_r.face_map      <= acf_pkg::RST_FACE_MAP;
    end else if (wr_en) begin
      case (wr_index)
        acf_pkg::CFG_ENABLE:     cfg_r.enable        <= wr_data[0];
        acf_pkg::CFG_MIN_CONF:   cfg_r.conf_floor    <= wr_data[7:0];
        acf_pkg::CFG_INST_CONF:  cfg_r.conf_instant  <= wr_data[7:0];
        acf_pkg::CFG_CONF_COUNT: cfg_r.confirm_count <= wr_data[7:0];
        acf_pkg::CFG_DWELL:      cfg_r.promote_dwell <= wr_data;
        acf_pkg::CFG_STALE:      cfg_r.stale_after   <= wr_data;
        acf_pkg::CFG_HOLD:       cfg_r.hold_time     <= wr_data;
        acf_pkg::CFG_FACE_MAP:   cfg_r.face_map      <= wr_data[20:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: src/acf_core.sv
// ----------------------------------------------------------------------------
// acf_core: qualifier state and single-pass update
// Applies one word to the evidence, face and counter state and forms its result.
// ----------------------------------------------------------------------------
module acf_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  acf_pkg::item_t item,
  input  acf_pkg::cfg_t  cfg,
  output acf_pkg::res_t  res,
  output logic           halted
);

  logic        halted_r, halted_nxt;
  logic [2:0]  shown_r, shown_nxt;
  logic [2:0]  emitted_r, emitted_nxt;
  logic [2:0]  confc_r, confc_nxt;
  logic [2:0]  pclass_r, pclass_nxt;
  logic [7:0]  prep_r, prep_nxt;
  logic [31:0] pstart_r, pstart_nxt;
  logic [7:0]  pconf_r, pconf_nxt;
  logic        have_r, have_nxt;
  logic [31:0] lread_r, lread_nxt;
  logic [31:0] lchg_r, lchg_nxt;
  logic        ever_r, ever_nxt;
  logic [31:0] cnt_r   [acf_pkg::CNT_NUM];
  logic [31:0] cnt_nxt [acf_pkg::CNT_NUM];

  logic        soft_rst;
  logic        emit;
  logic [2:0]  want;
  logic [31:0] age_read, age_pend, age_chg;
  logic        count_hit, conf_hit, dwell_hit;

  assign age_read  = item.now_ms - lread_r;
  assign age_pend  = item.now_ms - pstart_r;
  assign age_chg   = item.now_ms - lchg_r;
  assign count_hit = prep_r >= cfg.confirm_count;
  assign conf_hit  = pconf_r >= cfg.conf_instant;
  assign dwell_hit = (cfg.promote_dwell != 32'd0) && (age_pend >= cfg.promote_dwell);

  always_comb begin
    halted_nxt  = halted_r;
    shown_nxt   = shown_r;
    emitted_nxt = emitted_r;
    confc_nxt   = confc_r;
    pclass_nxt  = pclass_r;
    prep_nxt    = prep_r;
    pstart_nxt  = pstart_r;
    pconf_nxt   = pconf_r;
    have_nxt    = have_r;
    lread_nxt   = lread_r;
    lchg_nxt    = lchg_r;
    ever_nxt    = ever_r;
    cnt_nxt     = cnt_r;
    soft_rst    = 1'b0;
    emit        = 1'b0;
    want        = acf_pkg::FACE_IDLE;
    case (item.opcode)
      acf_pkg::OP_OBSERVE: begin
        cnt_nxt[acf_pkg::CNT_OBSERVED] = cnt_r[acf_pkg::CNT_OBSERVED] + 32'd1;
        if (!halted_r) begin
          if (item.affect == acf_pkg::CLS_UNKNOWN) begin
            cnt_nxt[acf_pkg::CNT_UNKNOWN] = cnt_r[acf_pkg::CNT_UNKNOWN] + 32'd1;
          end else if (item.confidence < cfg.conf_floor) begin
            cnt_nxt[acf_pkg::CNT_WEAK] = cnt_r[acf_pkg::CNT_WEAK] + 32'd1;
          end else begin
            cnt_nxt[acf_pkg::CNT_ACCEPTED] = cnt_r[acf_pkg::CNT_ACCEPTED] + 32'd1;
            have_nxt  = 1'b1;
            lread_nxt = item.now_ms;
            pconf_nxt = item.confidence;
            if (item.affect == pclass_r) begin
              if (prep_r != acf_pkg::REPEAT_MAX) prep_nxt = prep_r + 8'd1;
            end else begin
              pclass_nxt = item.affect;
              prep_nxt   = 8'd1;
              pstart_nxt = item.now_ms;
            end
          end
        end
      end
      acf_pkg::OP_UPDATE: begin
        if (halted_r) begin
          shown_nxt = acf_pkg::FACE_IDLE;
        end else if (!cfg.enable) begin
          shown_nxt  = acf_pkg::FACE_IDLE;
          confc_nxt  = acf_pkg::CLS_UNKNOWN;
          have_nxt   = 1'b0;
          pclass_nxt = acf_pkg::CLS_UNKNOWN;
          prep_nxt   = 8'd0;
        end else begin
          if (have_r && (age_read >= cfg.stale_after)) begin
            have_nxt   = 1'b0;
            pclass_nxt = acf_pkg::CLS_UNKNOWN;
            prep_nxt   = 8'd0;
            if (confc_r != acf_pkg::CLS_UNKNOWN)
              cnt_nxt[acf_pkg::CNT_DECAYS] = cnt_r[acf_pkg::CNT_DECAYS] + 32'd1;
            confc_nxt  = acf_pkg::CLS_UNKNOWN;
          end
          if ((pclass_nxt != acf_pkg::CLS_UNKNOWN) && (pclass_nxt != confc_nxt) &&
              (count_hit || conf_hit || dwell_hit))
            confc_nxt = pclass_nxt;
          want = acf_pkg::face_for(cfg.face_map, confc_nxt);
          if (want != shown_r) begin
            if (ever_r && (age_chg < cfg.hold_time)) begin
              cnt_nxt[acf_pkg::CNT_HELD] = cnt_r[acf_pkg::CNT_HELD] + 32'd1;
            end else begin
              shown_nxt = want;
              lchg_nxt  = item.now_ms;
              ever_nxt  = 1'b1;
              cnt_nxt[acf_pkg::CNT_CHANGES] = cnt_r[acf_pkg::CNT_CHANGES] + 32'd1;
            end
          end
        end
        if (!item.mute && (shown_nxt != emitted_r)) begin
          emitted_nxt = shown_nxt;
          emit        = 1'b1;
        end
      end
      acf_pkg::OP_HALT: begin
        if (item.halt_on != halted_r) begin
          halted_nxt = item.halt_on;
          soft_rst   = 1'b1;
        end
      end
      acf_pkg::OP_RESET: begin
        soft_rst = 1'b1;
      end
      default: ;
    endcase
    if (soft_rst) begin
      shown_nxt  = acf_pkg::FACE_IDLE;
      confc_nxt  = acf_pkg::CLS_UNKNOWN;
      pclass_nxt = acf_pkg::CLS_UNKNOWN;
      prep_nxt   = 8'd0;
      pstart_nxt = item.now_ms;
      pconf_nxt  = 8'd0;
      have_nxt   = 1'b0;
      lread_nxt  = item.now_ms;
      lchg_nxt   = item.now_ms;
      ever_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halted_r  <= 1'b0;
      shown_r   <= acf_pkg::FACE_IDLE;
      emitted_r <= acf_pkg::FACE_IDLE;
      confc_r   <= acf_pkg::CLS_UNKNOWN;
      pclass_r  <= acf_pkg::CLS_UNKNOWN;
      prep_r    <= 8'd0;
      pstart_r  <= 32'd0;
      pconf_r   <= 8'd0;
      have_r    <= 1'b0;
      lread_r   <= 32'd0;
      lchg_r    <= 32'd0;
      ever_r    <= 1'b0;
      for (int i = 0; i < acf_pkg::CNT_NUM; i++) cnt_r[i] <= 32'd0;
    end else if (fire) begin
      halted_r  <= halted_nxt;
      shown_r   <= shown_nxt;
      emitted_r <= emitted_nxt;
      confc_r   <= confc_nxt;
      pclass_r  <= pclass_nxt;
      prep_r    <= prep_nxt;
      pstart_r  <= pstart_nxt;
      pconf_r   <= pconf_nxt;
      have_r    <= have_nxt;
      lread_r   <= lread_nxt;
      lchg_r    <= lchg_nxt;
      ever_r    <= ever_nxt;
      for (int i = 0; i < acf_pkg::CNT_NUM; i++) cnt_r[i] <= cnt_nxt[i];
    end
  end

  always_comb begin
    res.face             = shown_nxt;
    res.emit_new         = emit;
    res.confirmed_affect = confc_nxt;
    for (int i = 0; i < acf_pkg::CNT_NUM; i++) res.cnt[i] = cnt_nxt[i];
  end

  assign halted = halted_r;

endmodule

FILE: src/affect_confirm_and_hold_top.sv
// ----------------------------------------------------------------------------
// affect_confirm_and_hold_top: affect confirm-and-hold qualifier
// Path: an accepted word is held in the input reg, then its result is loaded
// into the result reg; a stalled output keeps the word in the input reg.
// Throughput: one word per cycle while out_ready keeps the result reg free; the state update is one pass between regs.
// Reset: synchronous rst_n restores all settings to defaults, clears state
// and counters; the block accepts words in the first cycle after reset.
// ----------------------------------------------------------------------------
module affect_confirm_and_hold_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [2:0]  in_affect,
  input  logic [7:0]  in_confidence,
  input  logic [31:0] in_now_ms,
  input  logic        in_halt_on,
  input  logic        in_mute,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_face,
  output logic        out_emit_new,
  output logic [2:0]  out_confirmed_affect,
  output logic [31:0] out_count_observed,
  output logic [31:0] out_count_unknown,
  output logic [31:0] out_count_weak,
  output logic [31:0] out_count_accepted,
  output logic [31:0] out_count_decays,
  output logic [31:0] out_count_held,
  output logic [31:0] out_count_changes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  acf_pkg::cfg_t  cfg;
  acf_pkg::item_t s1_item_r;
  acf_pkg::res_t  core_res;
  acf_pkg::res_t  out_res_r;
  logic           s1_valid_r;
  logic           out_valid_r;
  logic           s1_adv;
  logic           s1_fire;
  logic           core_halted;

  assign cfg_ready = 1'b1;
  assign s1_adv    = !out_valid_r || out_ready;
  assign s1_fire   = s1_valid_r && s1_adv;
  assign in_ready  = !s1_valid_r || s1_adv;

  acf_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  acf_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (s1_fire),
    .item   (s1_item_r),
    .cfg    (cfg),
    .res    (core_res),
    .halted (core_halted)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.opcode     <= acf_pkg::op_t'(in_opcode);
      s1_item_r.affect     <= in_affect;
      s1_item_r.confidence <= in_confidence;
      s1_item_r.now_ms     <= in_now_ms;
      s1_item_r.halt_on    <= in_halt_on;
      s1_item_r.mute       <= in_mute;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_face             = out_res_r.face;
  assign out_emit_new         = out_res_r.emit_new;
  assign out_confirmed_affect = out_res_r.confirmed_affect;
  assign out_count_observed   = out_res_r.cnt[acf_pkg::CNT_OBSERVED];
  assign out_count_unknown    = out_res_r.cnt[acf_pkg::CNT_UNKNOWN];
  assign out_count_weak       = out_res_r.cnt[acf_pkg::CNT_WEAK];
  assign out_count_accepted   = out_res_r.cnt[acf_pkg::CNT_ACCEPTED];
  assign out_count_decays     = out_res_r.cnt[acf_pkg::CNT_DECAYS];
  assign out_count_held       = out_res_r.cnt[acf_pkg::CNT_HELD];
  assign out_count_changes    = out_res_r.cnt[acf_pkg::CNT_CHANGES];

  a_emit_only_update: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && (s1_item_r.opcode != acf_pkg::OP_UPDATE) |-> !core_res.emit_new)
    else $error("emit flagged on a non-update word");

  a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.face <= acf_pkg::FACE_MAX))
    else $error("face code out of range");

  a_halted_idle: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && core_halted && (s1_item_r.opcode != acf_pkg::OP_HALT) |->
      (core_res.face == acf_pkg::FACE_IDLE) &&
      (core_res.confirmed_affect == acf_pkg::CLS_UNKNOWN))
    else $error("halted block shows a face or confirmed class");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("processed word did not reach result register");

endmodule
